// File: hdl/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants for the skip-tolerant tag search
// Tag size, register map, byte codes and the structs passed between the
// top level and the match cells.
// ----------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

  localparam int MAX_PATTERN = 48;
  localparam int WORD_COUNT  = 6;
  localparam int LEN_W       = 6;
  localparam int CFG_W       = 64;
  localparam int IDX_W       = 3;
  localparam int CMP_W       = 7;

  localparam logic [IDX_W-1:0] REG_LENGTH     = 3'd0;
  localparam logic [IDX_W-1:0] REG_WORD_FIRST = 3'd1;

  localparam logic [7:0] LEAD_BIT  = 8'h80;
  localparam logic [7:0] CASE_BIT  = 8'h20;
  localparam logic [7:0] ESC_CODE  = 8'h1B;
  localparam logic [7:0] SPACE     = 8'h20;
  localparam logic [7:0] NEWLINE   = 8'h0A;
  localparam logic [7:0] SEMICOLON = 8'h3B;
  localparam logic [7:0] BRACKET   = 8'h5B;
  localparam logic [7:0] DIGIT_0   = 8'h30;
  localparam logic [7:0] DIGIT_9   = 8'h39;
  localparam logic [7:0] UPPER_A   = 8'h41;
  localparam logic [7:0] UPPER_Z   = 8'h5A;

  // classes of the folded byte, decoded once and shared by every cell
  typedef struct packed {
    logic is_skip;
    logic is_esc;
    logic is_body;
  } byte_class_t;

  // per-cell view of the active tag length
  typedef struct packed {
    logic active;
    logic tail;
  } cell_ctl_t;

  typedef struct packed {
    logic plain;
    logic esc;
  } cell_state_t;

endpackage

`default_nettype wire

// File: hdl/sts_cell.sv
// ----------------------------------------------------------------------------
// sts_cell: one tag position of the match chain
// Tracks an attempt that has matched k tag bytes, either waiting for tag
// byte k or inside a skipped escape sequence, and hands an advancing
// attempt to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_cell (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire logic                 clear,
  input  wire logic [7:0]           data,
  input  wire logic [7:0]           tag,
  input  wire sts_pkg::byte_class_t cls,
  input  wire sts_pkg::cell_ctl_t   ctl,
  input  wire logic                 adv_in,
  output      logic                 adv_out,
  output      logic                 hit,
  output      sts_pkg::cell_state_t state
);

  import sts_pkg::*;

  cell_state_t st_r, st_nxt;
  logic        p, e, match;

  always_comb begin
    // drop attempts at or beyond the active length
    p     = st_r.plain & ctl.active;
    e     = st_r.esc & ctl.active;
    match = (data == tag);

    adv_out = p & match & ~ctl.tail;
    hit     = p & match & ctl.tail;

    st_nxt.plain = adv_in | (p & ~match & cls.is_skip) | (e & ~cls.is_body);
    st_nxt.esc   = (p & ~match & cls.is_esc) | (e & cls.is_body);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (step) begin
      if (clear) begin
        st_r <= '0;
      end else begin
        st_r <= st_nxt;
      end
    end
  end

  assign state = st_r;

endmodule

`default_nettype wire

// File: hdl/skip_tolerant_tag_search.sv
// The result word is registered and valid in the cycle after the last byte.
// Throughput: one byte per cycle, except that a last byte waits only while the
// previous result word is still unread; every tag position is a cell of its own
// and all cells update together in the cycle the byte is taken.
// Reset clears all partial matches, the found flag and the output valid flag;
// the tag registers return to length 1 and all-zero tag bytes.
// ----------------------------------------------------------------------------
// skip_tolerant_tag_search: streaming tag search over a text
// Folds each byte, tracks every partial match in a chain of cells that
// skip spaces, newlines and escape sequences, and reports with the last
// byte whether the tag occurred.
// ----------------------------------------------------------------------------
`default_nettype none

module skip_tolerant_tag_search (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic [7:0]                  in_data_byte,
  input  wire logic                        in_last_byte,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic                        out_found,
  input  wire logic                        cfg_we,
  input  wire logic [sts_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [sts_pkg::CFG_W-1:0]   cfg_data
);

  import sts_pkg::*;

  logic [LEN_W-1:0] length_r;
  logic [CFG_W-1:0] word_r [WORD_COUNT];
  logic             trail_r;
  logic             found_r;
  logic             out_valid_r;
  logic             out_found_r;

  logic             acc;
  logic [CMP_W-1:0] len_ext, len_eff;
  logic [7:0]       folded;
  byte_class_t      cls;
  logic             start;
  logic             hit_any;

  logic [MAX_PATTERN:1]   link;
  logic [MAX_PATTERN-1:0] hit_vec;
  cell_state_t            state_vec [MAX_PATTERN];

  // a last byte needs room in the output register, other bytes never wait
  assign in_ready = ~out_valid_r | out_ready | ~in_last_byte;
  assign acc      = in_valid & in_ready;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r <= LEN_W'(1);
      for (int w = 0; w < WORD_COUNT; w++) begin
        word_r[w] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_LENGTH) begin
        length_r <= cfg_data[LEN_W-1:0];
      end
      for (int w = 0; w < WORD_COUNT; w++) begin
        if (cfg_index == REG_WORD_FIRST + IDX_W'(w)) begin
          word_r[w] <= cfg_data;
        end
      end
    end
  end

  // clamp the length into 1..MAX_PATTERN
  always_comb begin
    len_ext = CMP_W'(length_r);
    if (len_ext == '0) begin
      len_eff = CMP_W'(1);
    end else if (len_ext > CMP_W'(MAX_PATTERN)) begin
      len_eff = CMP_W'(MAX_PATTERN);
    end else begin
      len_eff = len_ext;
    end
  end

  // fold case unless this byte is the trail of a lead byte
  always_comb begin
    folded = in_data_byte;
    if (!trail_r && !in_data_byte[7] && in_data_byte >= UPPER_A &&
        in_data_byte <= UPPER_Z) begin
      folded = in_data_byte | CASE_BIT;
    end
    cls.is_skip = (folded == SPACE) || (folded == NEWLINE);
    cls.is_esc  = (folded == ESC_CODE);
    cls.is_body = (folded >= DIGIT_0 && folded <= DIGIT_9) ||
                  (folded == SEMICOLON) || (folded == BRACKET);
  end

  // a trail byte never opens an attempt
  assign start      = ~trail_r & (folded == word_r[0][7:0]);
  assign hit_vec[0] = start & (len_eff == CMP_W'(1));
  assign link[1]    = start & (len_eff > CMP_W'(1));
  assign state_vec[0] = '0;

  for (genvar k = 1; k < MAX_PATTERN; k++) begin : g_cell
    logic [7:0] tag_k;
    cell_ctl_t  ctl_k;

    if (k < WORD_COUNT * 8) begin : g_tag
      assign tag_k = word_r[k / 8][(k % 8) * 8 +: 8];
    end else begin : g_zero
      assign tag_k = 8'h00;
    end

    assign ctl_k.active = (CMP_W'(k) < len_eff);
    assign ctl_k.tail   = (CMP_W'(k) == len_eff - CMP_W'(1));

    sts_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .step    (acc),
      .clear   (in_last_byte),
      .data    (folded),
      .tag     (tag_k),
      .cls     (cls),
      .ctl     (ctl_k),
      .adv_in  (link[k]),
      .adv_out (link[k+1]),
      .hit     (hit_vec[k]),
      .state   (state_vec[k])
    );
  end

  assign hit_any = |hit_vec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trail_r <= 1'b0;
      found_r <= 1'b0;
    end else if (acc) begin
      if (in_last_byte) begin
        trail_r <= 1'b0;
        found_r <= 1'b0;
      end else begin
        trail_r <= ~trail_r & ((in_data_byte & LEAD_BIT) != 8'h00);
        found_r <= found_r | hit_any;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc && in_last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_last_byte) begin
      out_found_r <= found_r | hit_any;
    end
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;

  // the top cell can only hit, never hand an attempt further
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !link[MAX_PATTERN])
    else $error("attempt advanced past the last tag position");

  // a last byte never overwrites an unread result word
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_last_byte |-> !out_valid_r || out_ready)
    else $error("result word overwritten");

  // a text boundary leaves no state behind
  a_boundary_clear: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_last_byte |=> !found_r && !trail_r &&
      state_vec[MAX_PATTERN-1] == '0 && state_vec[1 % MAX_PATTERN] == '0)
    else $error("state left after last byte");

  // a trail byte is never itself a lead
  a_trail_single: assert property (@(posedge clk) disable iff (!rst_n)
    acc && trail_r |=> !trail_r)
    else $error("trail flag set on two bytes in a row");

  // a result word only follows an accepted last byte
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(acc && in_last_byte))
    else $error("result word without a last byte");

endmodule

`default_nettype wire
